@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ design/rfd_pkg.sv @@
// Types, constants and width helpers for the refraction direction unit.
`timescale 1ns / 1ps
package rfd_pkg;
   localparam int COMP_W = 16;
   localparam int RES_W  = 18;
   localparam int REQ_W  = 7 * COMP_W;
   localparam int RSP_W  = 56;
   localparam int SIDE_W = 3 * RES_W + 3 * COMP_W + 1;

   localparam int OUT_MAX = 131071;
   localparam int OUT_MIN = -131072;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic        [COMP_W-1:0] ratio_type;
   typedef logic signed [RES_W-1:0]  res_type;

   // |1 - len^2| needs room for the unit value and for a full length sum
   function automatic int diff_width(input int frac);
      int w;
      w = 2 * frac + 1;
      return (w > 36) ? w : 36;
   endfunction
endpackage

@@ design/refraction_direction.sv @@
// Top level of the refraction direction unit: stream ports and pipeline wiring.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Refraction direction unit (Snell's law in vector form, fixed point).
// req channel: one transaction carries incident vector I, surface normal N
//   (signed Q2.14) and index ratio eta (unsigned Q2.14).
// rsp channel: one transaction per request with the refracted direction
//   R = eta*(I + c*N) - sqrt(|1 - |perp|^2|)*N, c = -dot(I, N), in signed
//   Q4.14 saturated to 18 bits, plus a clipped flag when any clamp hit.
// Pipeline: eight stages form the perpendicular part and |1 - |perp|^2|, the
//   square root resolves one bit per stage, and two stages add the parallel
//   part and saturate.
// Throughput: one transaction per cycle while rsp_tready is high, results in
//   request order.
// Backpressure: each stage holds only while its successor is full, so
//   bubbles squeeze out and req_tready stays high until every stage holds a
//   transaction; nothing is dropped or repeated while rsp_tready is low.
// Reset clears all stage valid bits; payload registers are not reset.
module refraction_direction #(
   parameter int FRAC_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z,
   // eta_ratio (16 bits each, from bit 0 up)
   input  logic [rfd_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_x, out_y, out_z (18 bits each), clipped, one zero pad bit
   output logic [rfd_pkg::RSP_W-1:0] rsp_tdata
);
   import rfd_pkg::*;

   localparam int DW = diff_width(FRAC_BITS);
   localparam int QW = (DW + 1) / 2;

   comp_type  inc [3], nrm [3];
   ratio_type eta;

   logic            perp_valid, perp_ready, perp_hit;
   res_type         perp_q [3];
   comp_type        perp_nrm [3];
   logic [DW-1:0]   perp_diff;
   logic [SIDE_W-1:0] perp_side;

   logic              sq_valid, sq_ready;
   logic [QW-1:0]     sq_root;
   logic [SIDE_W-1:0] sq_side;
   res_type           sq_q [3];
   comp_type          sq_nrm [3];

   res_type res [3];
   logic    clipped;

   // unpack request fields, lowest first
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         inc[k] = req_tdata[COMP_W * k +: COMP_W];
         nrm[k] = req_tdata[COMP_W * (3 + k) +: COMP_W];
      end
      eta = req_tdata[COMP_W * 6 +: COMP_W];
   end

   rfd_perp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_perp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_inc    (inc),
      .in_nrm    (nrm),
      .in_eta    (eta),
      .out_valid (perp_valid),
      .out_ready (perp_ready),
      .out_q     (perp_q),
      .out_nrm   (perp_nrm),
      .out_hit   (perp_hit),
      .out_diff  (perp_diff)
   );

   // clamped perp, normal and flag ride alongside the root
   assign perp_side = {perp_hit, perp_nrm[2], perp_nrm[1], perp_nrm[0],
                       perp_q[2], perp_q[1], perp_q[0]};

   rfd_isqrt #(
      .DW   (DW),
      .SIDE (SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (perp_valid),
      .in_ready  (perp_ready),
      .in_d      (perp_diff),
      .in_side   (perp_side),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_q[k]   = sq_side[RES_W * k +: RES_W];
         sq_nrm[k] = sq_side[3 * RES_W + COMP_W * k +: COMP_W];
      end
   end

   rfd_out #(
      .FRAC_BITS (FRAC_BITS),
      .QW        (QW)
   ) u_out (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sq_valid),
      .in_ready    (sq_ready),
      .in_root     (sq_root),
      .in_q        (sq_q),
      .in_nrm      (sq_nrm),
      .in_hit      (sq_side[SIDE_W-1]),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_res     (res),
      .out_clipped (clipped)
   );

   assign rsp_tdata = {1'b0, clipped, res[2], res[1], res[0]};

   // an empty result register means every stage can advance
   `ASSERT_IMPLIES(a_ready_when_drained, !rsp_tvalid, req_tready)
   // a stalled hand-off into the root pipeline keeps its transaction
   `ASSERT_NEXT(a_perp_hold, perp_valid && !perp_ready, perp_valid)
   // a stalled root keeps its value until the output stage takes it
   `ASSERT_NEXT(a_root_hold, sq_valid && !sq_ready, $stable(sq_root) && sq_valid)
endmodule

@@ design/rfd_perp.sv @@
// Perpendicular component pipeline: cosine, eta scaling, clamp and |1 - |perp|^2|.
`timescale 1ns / 1ps
module rfd_perp #(
   parameter int FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rfd_pkg::comp_type  in_inc [3],
   input  rfd_pkg::comp_type  in_nrm [3],
   input  rfd_pkg::ratio_type in_eta,
   output logic               out_valid,
   input  logic               out_ready,
   output rfd_pkg::res_type   out_q [3],
   output rfd_pkg::comp_type  out_nrm [3],
   output logic               out_hit,
   output logic [rfd_pkg::diff_width(FRAC_BITS)-1:0] out_diff
);
   import rfd_pkg::*;

   localparam int NS  = 8;
   localparam int DW  = diff_width(FRAC_BITS);
   localparam int CW  = 34 - FRAC_BITS;                 // cosine
   localparam int MW  = 16 + CW;                        // normal * cosine
   localparam int HW  = ((50 - 2 * FRAC_BITS > 16) ? 50 - 2 * FRAC_BITS : 16) + 1;
   localparam int AW  = HW + 17;                        // high part * eta
   localparam int BW  = FRAC_BITS + 16;                 // low part * eta
   localparam int SW  = (AW + 1 > FRAC_BITS + 19) ? AW + 1 : FRAC_BITS + 19;
   localparam int PW  = SW - FRAC_BITS;
   localparam logic signed [PW-1:0] PMAX = PW'(OUT_MAX);
   localparam logic signed [PW-1:0] PMIN = PW'(OUT_MIN);
   localparam logic [DW-1:0] ONE = DW'(1) << (2 * FRAC_BITS);

   logic [NS-1:0] v_ff;
   logic [NS:0]   en;

   // stage 1
   logic signed [31:0] prod_ff [3];
   logic signed [31:0] prod_in [3];
   comp_type  inc1_ff [3], nrm1_ff [3];
   ratio_type eta1_ff;
   // stage 2
   logic signed [33:0]   dot_w, ndot_w;
   logic signed [CW-1:0] c_ff, c_in;
   comp_type  inc2_ff [3], nrm2_ff [3];
   ratio_type eta2_ff;
   // stage 3
   logic signed [MW-1:0] m_ff [3], m_in [3];
   comp_type  inc3_ff [3], nrm3_ff [3];
   ratio_type eta3_ff;
   // stage 4
   logic signed [HW-1:0]    th_ff [3], th_in [3];
   logic [FRAC_BITS-1:0]    tl_ff [3], tl_in [3];
   comp_type  nrm4_ff [3];
   ratio_type eta4_ff;
   // stage 5
   logic signed [AW-1:0] a_ff [3], a_in [3];
   logic [BW-1:0]        b_ff [3], b_in [3];
   comp_type nrm5_ff [3];
   // stage 6
   logic signed [SW-1:0] psum_w [3];
   logic signed [PW-1:0] p_w [3];
   logic [2:0]           clip_w;
   res_type  q6_ff [3], q6_in [3];
   logic     hit6_ff;
   comp_type nrm6_ff [3];
   // stage 7
   logic signed [35:0] sq_w [3];
   logic [34:0]        sq_ff [3], sq_in [3];
   res_type  q7_ff [3];
   logic     hit7_ff;
   comp_type nrm7_ff [3];
   // stage 8
   logic [DW-1:0] len_w, diff_ff, diff_in;
   res_type  q8_ff [3];
   logic     hit8_ff;
   comp_type nrm8_ff [3];

   // a stage takes new data when empty or when its successor moves
   always_comb begin
      en[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];

   always_comb begin
      dot_w  = 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]);
      ndot_w = -dot_w;
      c_in   = $signed(ndot_w[33:FRAC_BITS]);
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = 32'(in_inc[k]) * 32'(in_nrm[k]);
         m_in[k]    = MW'(nrm2_ff[k]) * MW'(c_ff);
         // t = I*2^F + N*c split at bit F: high part and unsigned low part
         th_in[k]   = HW'(inc3_ff[k]) + HW'($signed(m_ff[k][MW-1:FRAC_BITS]));
         tl_in[k]   = m_ff[k][FRAC_BITS-1:0];
         a_in[k]    = AW'(th_ff[k]) * AW'($signed({1'b0, eta4_ff}));
         b_in[k]    = BW'(tl_ff[k]) * BW'(eta4_ff);
         psum_w[k]  = SW'(a_ff[k]) + SW'($signed({1'b0, b_ff[k][BW-1:FRAC_BITS]}));
         p_w[k]     = $signed(psum_w[k][SW-1:FRAC_BITS]);
         if (p_w[k] > PMAX) begin
            q6_in[k]  = RES_W'(OUT_MAX);
            clip_w[k] = 1'b1;
         end else if (p_w[k] < PMIN) begin
            q6_in[k]  = RES_W'(OUT_MIN);
            clip_w[k] = 1'b1;
         end else begin
            q6_in[k]  = RES_W'(p_w[k]);
            clip_w[k] = 1'b0;
         end
         sq_w[k]  = 36'(q6_ff[k]) * 36'(q6_ff[k]);
         sq_in[k] = sq_w[k][34:0];
      end
      len_w   = DW'(sq_ff[0]) + DW'(sq_ff[1]) + DW'(sq_ff[2]);
      diff_in = (len_w >= ONE) ? len_w - ONE : ONE - len_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
         inc1_ff <= in_inc;
         nrm1_ff <= in_nrm;
         eta1_ff <= in_eta;
      end
      if (en[1]) begin
         c_ff    <= c_in;
         inc2_ff <= inc1_ff;
         nrm2_ff <= nrm1_ff;
         eta2_ff <= eta1_ff;
      end
      if (en[2]) begin
         m_ff    <= m_in;
         inc3_ff <= inc2_ff;
         nrm3_ff <= nrm2_ff;
         eta3_ff <= eta2_ff;
      end
      if (en[3]) begin
         th_ff   <= th_in;
         tl_ff   <= tl_in;
         nrm4_ff <= nrm3_ff;
         eta4_ff <= eta3_ff;
      end
      if (en[4]) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         nrm5_ff <= nrm4_ff;
      end
      if (en[5]) begin
         q6_ff   <= q6_in;
         hit6_ff <= |clip_w;
         nrm6_ff <= nrm5_ff;
      end
      if (en[6]) begin
         sq_ff   <= sq_in;
         q7_ff   <= q6_ff;
         hit7_ff <= hit6_ff;
         nrm7_ff <= nrm6_ff;
      end
      if (en[7]) begin
         diff_ff <= diff_in;
         q8_ff   <= q7_ff;
         hit8_ff <= hit7_ff;
         nrm8_ff <= nrm7_ff;
      end
   end

   assign out_q    = q8_ff;
   assign out_nrm  = nrm8_ff;
   assign out_hit  = hit8_ff;
   assign out_diff = diff_ff;
endmodule

@@ design/rfd_isqrt.sv @@
// Pipelined floor square root, one root bit per stage, with a side payload.
`timescale 1ns / 1ps
module rfd_isqrt #(
   parameter int DW   = 36,
   parameter int SIDE = 103
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DW-1:0]         in_d,
   input  logic [SIDE-1:0]       in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [(DW+1)/2-1:0]   out_root,
   output logic [SIDE-1:0]       out_side
);
   localparam int QW = (DW + 1) / 2;
   localparam int EW = 2 * QW;

   logic [QW-1:0] v_ff;
   logic [QW:0]   en;

   logic [EW-1:0]   rem_ff [QW], rem_src [QW], rem_in [QW];
   logic [QW-1:0]   root_ff [QW], root_src [QW], root_in [QW];
   logic [SIDE-1:0] side_ff [QW], side_src [QW];
   logic [EW:0]     term_w [QW];
   logic [QW-1:0]   take_w;

   always_comb begin
      en[QW] = out_ready;
      for (int k = QW - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   always_comb begin
      rem_src[0]  = EW'(in_d);
      root_src[0] = '0;
      side_src[0] = in_side;
      for (int k = 1; k < QW; k++) begin
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
      // trial bit j: (r + 2^j)^2 - r^2 = r*2^(j+1) + 2^(2j)
      for (int k = 0; k < QW; k++) begin
         term_w[k] = ((EW + 1)'(root_src[k]) << (QW - k))
                   + ((EW + 1)'(1) << (2 * (QW - 1 - k)));
         take_w[k] = {1'b0, rem_src[k]} >= term_w[k];
         if (take_w[k]) begin
            rem_in[k]  = EW'({1'b0, rem_src[k]} - term_w[k]);
            root_in[k] = root_src[k] | (QW'(1) << (QW - 1 - k));
         end else begin
            rem_in[k]  = rem_src[k];
            root_in[k] = root_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < QW; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QW; k++) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_root  = root_ff[QW-1];
   assign out_side  = side_ff[QW-1];
endmodule

@@ design/rfd_out.sv @@
// Parallel component, final sum, saturation and the result register.
`timescale 1ns / 1ps
module rfd_out #(
   parameter int FRAC_BITS = 14,
   parameter int QW        = 18
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [QW-1:0]     in_root,
   input  rfd_pkg::res_type  in_q [3],
   input  rfd_pkg::comp_type in_nrm [3],
   input  logic              in_hit,
   output logic              out_valid,
   input  logic              out_ready,
   output rfd_pkg::res_type  out_res [3],
   output logic              out_clipped
);
   import rfd_pkg::*;

   localparam int PRW = QW + 17;
   localparam int NGW = QW + 18;
   localparam int PAW = NGW - FRAC_BITS;
   localparam int RW  = ((PAW > RES_W) ? PAW : RES_W) + 1;
   localparam logic signed [RW-1:0] RMAX = RW'(OUT_MAX);
   localparam logic signed [RW-1:0] RMIN = RW'(OUT_MIN);

   logic [1:0] v_ff;
   logic [2:0] en;

   logic signed [PRW-1:0] prod_ff [3], prod_in [3];
   res_type               q_ff [3];
   logic                  hit_ff;
   logic signed [NGW-1:0] neg_w [3];
   logic signed [PAW-1:0] par_w [3];
   logic signed [RW-1:0]  sum_w [3];
   logic [2:0]            clip_w;
   res_type               res_ff [3], res_in [3];
   logic                  clip_ff;

   assign en[2]    = out_ready;
   assign en[1]    = !v_ff[1] || en[2];
   assign en[0]    = !v_ff[0] || en[1];
   assign in_ready = en[0];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = PRW'($signed({1'b0, in_root})) * PRW'(in_nrm[k]);
         neg_w[k]   = -(NGW'(prod_ff[k]));
         par_w[k]   = $signed(neg_w[k][NGW-1:FRAC_BITS]);
         sum_w[k]   = RW'(q_ff[k]) + RW'(par_w[k]);
         if (sum_w[k] > RMAX) begin
            res_in[k] = RES_W'(OUT_MAX);
            clip_w[k] = 1'b1;
         end else if (sum_w[k] < RMIN) begin
            res_in[k] = RES_W'(OUT_MIN);
            clip_w[k] = 1'b1;
         end else begin
            res_in[k] = RES_W'(sum_w[k]);
            clip_w[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         if (en[1]) begin
            v_ff[1] <= v_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
         q_ff    <= in_q;
         hit_ff  <= in_hit;
      end
      if (en[1]) begin
         res_ff  <= res_in;
         clip_ff <= hit_ff | (|clip_w);
      end
   end

   assign out_valid   = v_ff[1];
   assign out_res     = res_ff;
   assign out_clipped = clip_ff;
endmodule

@@ sim/refraction_direction_tb.sv @@
// Self-checking testbench for the refraction direction unit.
`timescale 1ns / 1ps
module refraction_direction_tb;
   import rfd_pkg::*;

   localparam int FRAC = 14;
   localparam int CLK_PERIOD = 10;
   // The drain allows for the pipeline latency and some slack.
   localparam int DRAIN_CYCLES = 40;

   // One ray: incident direction, surface normal and index ratio.
   typedef struct {
      comp_type  inc_x;
      comp_type  inc_y;
      comp_type  inc_z;
      comp_type  nrm_x;
      comp_type  nrm_y;
      comp_type  nrm_z;
      ratio_type eta;
   } ray_t;

   // One refracted direction as it leaves the block.
   typedef struct {
      res_type out_x;
      res_type out_y;
      res_type out_z;
      logic    clipped;
   } dir_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z, eta_ratio
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // out_x, out_y, out_z, clipped, zero pad
   logic [RSP_W-1:0]  rsp_tdata;

   dir_t pending_dirs[$];
   int   mismatch_count = 0;
   bit   idling_on = 1'b0;
   int   req_gap_odds = 0;      // 0: sender never pauses; n: one chance in n
   int   stall_cycles = 0;
   int   calm_cycles = 0;

   refraction_direction #(
      .FRAC_BITS(FRAC)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Clamp to the 18-bit result range, noting any hit.
   function automatic longint saturate_res(input longint v, inout bit hit);
      if (v > OUT_MAX) begin
         hit = 1'b1;
         return OUT_MAX;
      end
      if (v < OUT_MIN) begin
         hit = 1'b1;
         return OUT_MIN;
      end
      return v;
   endfunction

   // Refracted direction R = eta*(I + c*N) - sqrt(|1 - |perp|^2|)*N, c = -dot(I, N).
   // All right shifts floor (arithmetic shift on signed 64-bit values).
   function automatic dir_t refract_ray(input ray_t r);
      longint inc[3];
      longint nrm[3];
      longint perp[3];
      longint res[3];
      longint eta;
      longint cosv;
      longint t;
      longint len2;
      longint diff;
      longint rem;
      longint root;
      longint bitv;
      bit     hit;
      dir_t   d;
      inc[0] = r.inc_x;
      inc[1] = r.inc_y;
      inc[2] = r.inc_z;
      nrm[0] = r.nrm_x;
      nrm[1] = r.nrm_y;
      nrm[2] = r.nrm_z;
      eta    = longint'({48'd0, r.eta});
      hit    = 1'b0;
      cosv   = (-(inc[0] * nrm[0] + inc[1] * nrm[1] + inc[2] * nrm[2])) >>> FRAC;
      len2   = 0;
      for (int k = 0; k < 3; k++) begin
         t       = inc[k] * (longint'(1) <<< FRAC) + nrm[k] * cosv;
         perp[k] = saturate_res((t * eta) >>> (2 * FRAC), hit);
         len2   += perp[k] * perp[k];
      end
      diff = (longint'(1) <<< (2 * FRAC)) - len2;
      if (diff < 0) begin
         diff = -diff;      // past the critical angle: keep the magnitude
      end
      // floor square root, two bits of the radicand per step
      rem  = diff;
      root = 0;
      bitv = longint'(1) <<< 62;
      while (bitv > rem) begin
         bitv = bitv >> 2;
      end
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      for (int k = 0; k < 3; k++) begin
         res[k] = saturate_res(perp[k] + ((-(root * nrm[k])) >>> FRAC), hit);
      end
      d.out_x   = res_type'(res[0]);
      d.out_y   = res_type'(res[1]);
      d.out_z   = res_type'(res[2]);
      d.clipped = hit;
      return d;
   endfunction

   function automatic ray_t mk_ray(input int ix, input int iy, input int iz,
                                    input int nx, input int ny, input int nz,
                                    input int eta);
      ray_t r;
      r.inc_x = comp_type'(ix);
      r.inc_y = comp_type'(iy);
      r.inc_z = comp_type'(iz);
      r.nrm_x = comp_type'(nx);
      r.nrm_y = comp_type'(ny);
      r.nrm_z = comp_type'(nz);
      r.eta   = ratio_type'(eta);
      return r;
   endfunction

   // Mix of raw bit patterns, near-unit geometry and extreme ratios.
   function automatic ray_t random_ray();
      ray_t r;
      int   style;
      style = $urandom_range(0, 2);
      if (style == 0) begin
         r = mk_ray($urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
         r = mk_ray($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                    $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                    $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                    $urandom_range(8192, 32768));
         if (style == 2) begin
            r.eta = ($urandom_range(0, 1) == 1) ? ratio_type'($urandom_range(60000, 65535))
                                                : ratio_type'($urandom_range(0, 64));
         end
      end
      return r;
   endfunction

   // Drive one request transaction, optionally after a random pause, and record
   // the expected direction once it is accepted. Called just after a rising edge.
   task automatic send_ray(input ray_t r);
      if (req_gap_odds != 0 && $urandom_range(0, req_gap_odds - 1) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.eta, r.nrm_z, r.nrm_y, r.nrm_x, r.inc_z, r.inc_y, r.inc_x};
      do @(posedge clock); while (!req_tready);
      pending_dirs.push_back(refract_ray(r));
   endtask

   // Result side: random stall bursts, broken up by calm stretches.
   always @(posedge clock) begin
      if (stall_cycles > 0) begin
         stall_cycles = stall_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (calm_cycles > 0) begin
         calm_cycles = calm_cycles - 1;
         rsp_tready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_cycles = $urandom_range(1, 16) - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (idling_on && $urandom_range(0, 63) == 0) begin
            calm_cycles = $urandom_range(30, 100);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Compare each accepted result transaction with the oldest expectation.
   always @(posedge clock) begin
      dir_t got;
      dir_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.out_x   = rsp_tdata[RES_W-1:0];
         got.out_y   = rsp_tdata[2*RES_W-1:RES_W];
         got.out_z   = rsp_tdata[3*RES_W-1:2*RES_W];
         got.clipped = rsp_tdata[3*RES_W];
         if (pending_dirs.size() == 0) begin
            $error("result transaction with no expectation waiting");
            mismatch_count++;
         end else begin
            want = pending_dirs.pop_front();
            if (got.out_x !== want.out_x) begin
               $error("out_x: expected %0d, got %0d", want.out_x, got.out_x);
               mismatch_count++;
            end
            if (got.out_y !== want.out_y) begin
               $error("out_y: expected %0d, got %0d", want.out_y, got.out_y);
               mismatch_count++;
            end
            if (got.out_z !== want.out_z) begin
               $error("out_z: expected %0d, got %0d", want.out_z, got.out_z);
               mismatch_count++;
            end
            if (got.clipped !== want.clipped) begin
               $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
               mismatch_count++;
            end
         end
      end
   end

   // Corner values of every field, alternating bit patterns.
   task automatic test_field_extremes();
      send_ray(mk_ray(0, 0, 0, 0, 0, 0, 0));
      send_ray(mk_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535));
      send_ray(mk_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
      send_ray(mk_ray(32767, -32768, 32767, -32768, 32767, -32768, 65535));
      send_ray(mk_ray(-32768, 32767, -32768, 32767, -32768, 32767, 0));
      send_ray(mk_ray('hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA));
      send_ray(mk_ray('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555));
      send_ray(mk_ray(1, -1, 1, -1, 1, -1, 1));
      send_ray(mk_ray(0, 0, -16384, 0, 0, 16384, 16384));   // head-on, eta 1.0
   endtask

   // Clamping on either path, past the critical angle, odd geometry.
   task automatic test_special_cases();
      // perpendicular part out of range before it reaches the length
      send_ray(mk_ray(32767, 32767, 32767, -32768, 0, 0, 65535));
      // perpendicular fits, the parallel part pushes the sum past either rail
      send_ray(mk_ray(32767, 0, 0, 0, -32768, 0, 65535));
      send_ray(mk_ray(-32768, 0, 0, 0, 32767, 0, 65535));
      // total internal reflection: glass to air at a steep angle
      send_ray(mk_ray(14746, 0, -7143, 0, 0, 16384, 24576));
      // grazing: perpendicular length exactly one
      send_ray(mk_ray(16384, 0, 0, 0, 0, 16384, 16384));
      // 45 degrees into a denser medium
      send_ray(mk_ray(11585, 0, -11585, 0, 0, 16384, 12288));
      // normal facing along the incident ray
      send_ray(mk_ray(0, 0, 16384, 0, 0, 16384, 16384));
      // vectors that are not unit length
      send_ray(mk_ray(8192, 8192, 0, 0, 0, 8192, 16384));
      send_ray(mk_ray(30000, -30000, 20000, 4000, 4000, -4000, 40000));
   endtask

   // Random rays with idling on both sides; sender pauses vary per block.
   task automatic test_random_rays();
      idling_on = 1'b1;
      for (int blk = 0; blk < 12; blk++) begin
         req_gap_odds = (blk % 3 == 2) ? 0 : $urandom_range(2, 6);
         for (int n = 0; n < 32; n++) begin
            send_ray(random_ray());
         end
      end
   endtask

   // Closing stretch at full rate, no idling anywhere.
   task automatic test_back_to_back();
      idling_on    = 1'b0;
      req_gap_odds = 0;
      for (int n = 0; n < 70; n++) begin
         send_ray(random_ray());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_special_cases();
      test_random_rays();
      test_back_to_back();
      req_tvalid <= 1'b0;
      wait (pending_dirs.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: about 475 transactions, with wide margin for the worst case of
   // pauses and stalls.
   initial begin
      #(200_000 * CLK_PERIOD);
      $display("Test completed with failures");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+design
design/rfd_pkg.sv
design/rfd_perp.sv
design/rfd_isqrt.sv
design/rfd_out.sv
design/refraction_direction.sv
sim/refraction_direction_tb.sv
